[design/whf_pkg.sv]
// Shared types, codes, constants and the arctangent table of the waypoint heading follower.
package whf_pkg;

  localparam int MAX_WAYPOINTS_DEF = 16;
  localparam int CORDIC_STEPS_DEF  = 14;
  localparam int ATAN_LEN          = 20;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [17:0] PI_Q     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q = 18'sd51472;
  localparam logic signed [15:0] PI_Q16   = 16'sd25736;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_POSE = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [1:0] ST_TRACK    = 2'd0;
  localparam logic [1:0] ST_REACHED  = 2'd1;
  localparam logic [1:0] ST_FINISHED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_ANG  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WP_COUNT  = 3'd5;

  localparam logic [11:0] CRUISE_RST   = 12'd410;
  localparam logic [15:0] GAIN_RST     = 16'd8192;
  localparam logic [14:0] LIMIT_RST    = 15'd12288;
  localparam logic [11:0] TOL_RST      = 12'd205;
  localparam logic [14:0] STOP_ANG_RST = 15'd6554;
  localparam logic [4:0]  WP_COUNT_RST = 5'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_POSE,
    OP_READ,
    OP_FINISH,
    OP_DIFF,
    OP_SQX,
    OP_SQY,
    OP_REACHED,
    OP_INIT,
    OP_STEP,
    OP_ERR,
    OP_MUL,
    OP_ROUND,
    OP_OUT
  } whf_op_t;

  typedef struct packed {
    whf_op_t op;
  } whf_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       pose_valid;
    logic       route_done;
    logic       near;
    logic       step_last;
    logic       out_free;
  } whf_stat_t;

  function automatic logic [12:0] whf_atan(input logic [4:0] idx);
    logic [12:0] a;
    case (idx)
      5'd0:    a = 13'd6434;
      5'd1:    a = 13'd3798;
      5'd2:    a = 13'd2007;
      5'd3:    a = 13'd1019;
      5'd4:    a = 13'd511;
      5'd5:    a = 13'd256;
      5'd6:    a = 13'd128;
      5'd7:    a = 13'd64;
      5'd8:    a = 13'd32;
      5'd9:    a = 13'd16;
      5'd10:   a = 13'd8;
      5'd11:   a = 13'd4;
      5'd12:   a = 13'd2;
      5'd13:   a = 13'd1;
      default: a = 13'd0;
    endcase
    return a;
  endfunction

endpackage

[design/whf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module whf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/whf_ctrl.sv]
// Sequencing state machine of the waypoint heading follower.
module whf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  whf_pkg::whf_stat_t stat,
  output whf_pkg::whf_cmd_t  cmd
);
  import whf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_CMP,
    S_STEP,
    S_ERR,
    S_MUL,
    S_ROUND,
    S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (stat.func)
          FUNC_LOAD: cmd.op = OP_LOAD;
          FUNC_POSE: cmd.op = OP_POSE;
          FUNC_TICK: begin
            if (stat.pose_valid && stat.route_done) begin
              cmd.op     = OP_FINISH;
              state_next = S_DONE;
            end else if (stat.pose_valid) begin
              cmd.op     = OP_READ;
              state_next = S_DIFF;
            end
          end
          default: cmd.op = OP_NONE;
        endcase
      end
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_SQX;
      end
      S_SQX: begin
        cmd.op     = OP_SQX;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.op     = OP_SQY;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.near) begin
          cmd.op     = OP_REACHED;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_INIT;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.op = OP_STEP;
        if (stat.step_last) begin
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.op     = OP_ERR;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.op     = OP_ROUND;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      s_axis_tready <= 1'b1;
    end else begin
      state         <= state_next;
      s_axis_tready <= (state_next == S_IDLE);
    end
  end

endmodule

[design/whf_datapath.sv]
// Datapath: waypoint table, pose, configuration, distance test, iterative CORDIC and output.
module whf_datapath #(
  parameter int MAX_WAYPOINTS = whf_pkg::MAX_WAYPOINTS_DEF,
  parameter int CORDIC_STEPS  = whf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [55:0]                    s_axis_tdata,
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,
  input  logic                           cfg_we,
  input  logic [whf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [whf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  whf_pkg::whf_cmd_t              cmd,
  output whf_pkg::whf_stat_t             stat
);
  import whf_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WAYPOINTS);
  localparam int IW     = $clog2(CORDIC_STEPS);
  localparam int CW     = 26;

  logic [11:0] cfg_cruise;
  logic [15:0] cfg_gain;
  logic [14:0] cfg_limit;
  logic [11:0] cfg_tol;
  logic [14:0] cfg_stop_ang;
  logic [4:0]  cfg_count;

  logic [1:0]         in_func;
  logic [3:0]         in_slot;
  logic signed [15:0] in_x;
  logic signed [15:0] in_y;
  logic signed [15:0] in_head;

  logic signed [15:0] pose_x;
  logic signed [15:0] pose_y;
  logic signed [15:0] pose_head;
  logic               pose_valid;
  logic [4:0]         target_ptr;

  logic               ram_we;
  logic [31:0]        ram_rdata;
  logic signed [15:0] wp_x;
  logic signed [15:0] wp_y;

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic               zero_off;
  logic [23:0]        tol2;
  logic [32:0]        d2;
  logic signed [33:0] sqx;
  logic signed [33:0] sqy;
  logic [4:0]         route_len;

  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic signed [17:0]   cz;
  logic signed [17:0]   at_step;
  logic [IW-1:0]        iter;

  logic signed [17:0] zc;
  logic signed [17:0] ang;
  logic signed [17:0] e0;
  logic signed [17:0] ew;
  logic [14:0]        mag_c;
  logic [14:0]        mag;
  logic               err_neg;
  logic [30:0]        prod;
  logic [31:0]        rsum;
  logic [19:0]        rq;
  logic [14:0]        wmag;

  logic [11:0]        res_speed;
  logic signed [15:0] res_turn;
  logic [1:0]         res_status;

  assign wp_x   = ram_rdata[15:0];
  assign wp_y   = ram_rdata[31:16];
  assign ram_we = (cmd.op == OP_LOAD) && (int'(in_slot) < MAX_WAYPOINTS);

  whf_ram #(
    .WIDTH (32),
    .DEPTH (MAX_WAYPOINTS)
  ) u_wp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_slot)),
    .wdata ({in_y, in_x}),
    .raddr (ADDR_W'(target_ptr)),
    .rdata (ram_rdata)
  );

  assign route_len = (int'(cfg_count) > MAX_WAYPOINTS) ? 5'(MAX_WAYPOINTS) : cfg_count;
  assign sqx       = 34'(dx) * 34'(dx);
  assign sqy       = 34'(dy) * 34'(dy);

  assign x0      = {{3{dx[16]}}, dx, 6'd0};
  assign y0      = {{3{dy[16]}}, dy, 6'd0};
  assign sx      = cx >>> iter;
  assign sy      = cy >>> iter;
  assign at_step = signed'({5'd0, whf_atan(5'(iter))});

  always_comb begin
    if (cz > PI_Q) begin
      zc = PI_Q;
    end else if (cz < -PI_Q) begin
      zc = -PI_Q;
    end else begin
      zc = cz;
    end
    ang = zero_off ? 18'sd0 : zc;
    e0  = ang - {{2{pose_head[15]}}, pose_head};
    if (e0 > PI_Q) begin
      ew = e0 - TWO_PI_Q;
    end else if (e0 < -PI_Q) begin
      ew = e0 + TWO_PI_Q;
    end else begin
      ew = e0;
    end
    mag_c = ew[17] ? 15'(-ew) : 15'(ew);
  end

  assign rsum = {1'b0, prod} + 32'd2048;
  assign rq   = rsum[31:12];
  assign wmag = (rq > {5'd0, cfg_limit}) ? cfg_limit : rq[14:0];

  assign stat.func       = in_func;
  assign stat.pose_valid = pose_valid;
  assign stat.route_done = (target_ptr >= route_len);
  assign stat.near       = (d2 < {9'd0, tol2});
  assign stat.step_last  = (iter == IW'(CORDIC_STEPS - 1));
  assign stat.out_free   = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cruise   <= CRUISE_RST;
      cfg_gain     <= GAIN_RST;
      cfg_limit    <= LIMIT_RST;
      cfg_tol      <= TOL_RST;
      cfg_stop_ang <= STOP_ANG_RST;
      cfg_count    <= WP_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CRUISE:   cfg_cruise   <= cfg_wdata[11:0];
        CFG_GAIN:     cfg_gain     <= cfg_wdata[15:0];
        CFG_LIMIT:    cfg_limit    <= cfg_wdata[14:0];
        CFG_TOL:      cfg_tol      <= cfg_wdata[11:0];
        CFG_STOP_ANG: cfg_stop_ang <= cfg_wdata[14:0];
        CFG_WP_COUNT: cfg_count    <= cfg_wdata[4:0];
        default:      cfg_count    <= cfg_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x        <= '0;
      pose_y        <= '0;
      pose_head     <= '0;
      pose_valid    <= 1'b0;
      target_ptr    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.op == OP_POSE) begin
        pose_x     <= in_x;
        pose_y     <= in_y;
        pose_valid <= 1'b1;
        if (in_head > PI_Q16) begin
          pose_head <= PI_Q16;
        end else if (in_head < -PI_Q16) begin
          pose_head <= -PI_Q16;
        end else begin
          pose_head <= in_head;
        end
      end
      if (cmd.op == OP_REACHED) begin
        target_ptr <= target_ptr + 5'd1;
      end
      if (cmd.op == OP_OUT) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        in_func <= s_axis_tuser;
        in_slot <= s_axis_tdata[3:0];
        in_x    <= s_axis_tdata[19:4];
        in_y    <= s_axis_tdata[35:20];
        in_head <= s_axis_tdata[51:36];
      end
      OP_FINISH: begin
        res_speed  <= '0;
        res_turn   <= '0;
        res_status <= ST_FINISHED;
      end
      OP_DIFF: begin
        dx       <= {wp_x[15], wp_x} - {pose_x[15], pose_x};
        dy       <= {wp_y[15], wp_y} - {pose_y[15], pose_y};
        zero_off <= (wp_x == pose_x) && (wp_y == pose_y);
        tol2     <= 24'(cfg_tol) * 24'(cfg_tol);
      end
      OP_SQX: d2 <= sqx[32:0];
      OP_SQY: d2 <= d2 + sqy[32:0];
      OP_REACHED: begin
        res_speed  <= '0;
        res_turn   <= '0;
        res_status <= ST_REACHED;
      end
      OP_INIT: begin
        iter <= '0;
        if (dx[16]) begin
          cx <= -x0;
          cy <= -y0;
          cz <= dy[16] ? -PI_Q : PI_Q;
        end else begin
          cx <= x0;
          cy <= y0;
          cz <= '0;
        end
      end
      OP_STEP: begin
        iter <= iter + IW'(1);
        if (cy > 0) begin
          cx <= cx + sy;
          cy <= cy - sx;
          cz <= cz + at_step;
        end else begin
          cx <= cx - sy;
          cy <= cy + sx;
          cz <= cz - at_step;
        end
      end
      OP_ERR: begin
        mag       <= mag_c;
        err_neg   <= ew[17];
        res_speed <= (mag_c > cfg_stop_ang) ? 12'd0 : cfg_cruise;
      end
      OP_MUL: prod <= 31'(cfg_gain) * 31'(mag);
      OP_ROUND: begin
        res_turn   <= err_neg ? -signed'({1'b0, wmag}) : signed'({1'b0, wmag});
        res_status <= ST_TRACK;
      end
      OP_OUT: begin
        m_axis_tdata <= {7'd0, target_ptr, res_turn, res_speed};
        m_axis_tuser <= res_status;
      end
      default: iter <= iter;
    endcase
  end

endmodule

[design/waypoint_heading_follower.sv]
// Top level of the waypoint heading follower: controller plus datapath.
// Load and pose transfers go via decode back to idle; the next item is taken right after.
// A steering tick runs decode, difference, squares, compare, the CORDIC steps, error,
// multiply and round before its result is offered, the shared CORDIC stage doing one
// vectoring step per cycle; a reached tick skips from compare to output, a finished tick
// goes from decode to output, and a stalled result holds the input off until it is taken.
// rst is synchronous: clears pose, target index and output valid, reloads register defaults.
module waypoint_heading_follower #(
  parameter int MAX_WAYPOINTS = whf_pkg::MAX_WAYPOINTS_DEF,
  parameter int CORDIC_STEPS  = whf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [55:0]                    s_axis_tdata,  // slot, x_pos, y_pos, heading
  input  logic [1:0]                     s_axis_tuser,  // func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // speed_cmd, turn_cmd, target_index
  output logic [1:0]                     m_axis_tuser,  // status
  input  logic                           cfg_we,
  input  logic [whf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [whf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import whf_pkg::*;

  whf_cmd_t  cmd;
  whf_stat_t stat;

  whf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  whf_datapath #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS),
    .CORDIC_STEPS  (CORDIC_STEPS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

[design/whf_checker.sv]
// Port-level checker for the waypoint heading follower, bound to the top level.
module whf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import whf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transfer taken while an item is in work");

  a_zero_cmd: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_REACHED || m_axis_tuser == ST_FINISHED) |->
      m_axis_tdata[27:0] == 28'd0)
    else $error("nonzero command on reached or finished result");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

endmodule

bind waypoint_heading_follower whf_checker u_whf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
